[hw/rtl/trapezoidal_linear_move_profile_unit_macros.svh]
// assertion macros used by the checker file
`ifndef TRAPEZOIDAL_LINEAR_MOVE_PROFILE_UNIT_MACROS_SVH
`define TRAPEZOIDAL_LINEAR_MOVE_PROFILE_UNIT_MACROS_SVH

// property that holds at every clock edge out of reset
`define TLMP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tlmp check failed");

// condition implies property in the same cycle
`define TLMP_IMPLY(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tlmp check failed");

// condition implies property in the next cycle
`define TLMP_IMPLY_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("tlmp check failed");

`endif

[hw/rtl/tlmp_pkg.sv]
`default_nettype none
package tlmp_pkg;

  // operation codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_TARGET = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // register indexes
  localparam logic [2:0] REG_STEP_INTERVAL = 3'd0;
  localparam logic [2:0] REG_MAX_SPEED     = 3'd1;
  localparam logic [2:0] REG_ACCEL         = 3'd2;
  localparam logic [2:0] REG_DECEL         = 3'd3;
  localparam logic [2:0] REG_REACH         = 3'd4;
  localparam logic [2:0] REG_NONE          = 3'd7;

  // register reset values
  localparam logic [15:0] RST_STEP_INTERVAL = 16'd6;
  localparam logic [15:0] RST_MAX_SPEED     = 16'd15360;
  localparam logic [17:0] RST_ACCEL         = 18'd23040;
  localparam logic [17:0] RST_DECEL         = 18'd30720;
  localparam logic [15:0] RST_REACH         = 16'd256;

  // divide by 1000 as (x >> 3) * ceil(2^38 / 125) >> 38, exact for x below 2^34
  localparam logic [31:0] RECIP_125 = 32'd2199023256;

  // iteration counts of the shared unit
  localparam logic [4:0] SQRT_STEPS = 5'd21;
  localparam logic [4:0] DIV_STEPS  = 5'd25;

  typedef struct packed {
    logic [1:0]         operation;
    logic [31:0]        now_ms;
    logic signed [19:0] coord_x;
    logic signed [19:0] coord_y;
    logic signed [19:0] coord_z;
  } tlmp_in_t;

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic [15:0]        speed_now;
    logic               moving;
    logic               arrived;
    logic               stepped;
  } tlmp_out_t;

  // request to the shared divide / square root unit
  typedef struct packed {
    logic start;
    logic sqrt;
  } tlmp_iter_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_REACH,
    ST_ARR_CMP,
    ST_DD,
    ST_SS,
    ST_DEC_CMP,
    ST_RATE,
    ST_RATE_GO,
    ST_SPEED,
    ST_STEP,
    ST_STEP_GO,
    ST_STEP_SAVE,
    ST_MV_MUL,
    ST_MV_GO,
    ST_MV_UPD,
    ST_WAIT,
    ST_DONE
  } tlmp_state_t;

endpackage
`default_nettype wire

[hw/rtl/trapezoidal_linear_move_profile_unit.sv]
`default_nettype none
// Straight-line 3D move generator with a trapezoidal speed profile. Operations:
// tick (0), set target (1) and load position (2); code 3 only reports state.
// Every transaction gives one result. Set, load, code 3 and a tick that takes
// no step go straight to the result; a tick that finds the target within
// reach stops after the distance check, and a tick that steps also runs the
// shared bit-serial divide / square root unit: one root of 21 bits and three
// rounded quotients of 25 bits, each one bit per cycle, with a single 32x32
// multiplier feeding it that also scales by 1/1000 through a reciprocal. The
// block takes no new transaction while one is in work or while its result
// waits in the output register, so the next input transaction comes in the
// cycle after the result transaction at the earliest.
// Configuration writes are always ready and are expected only while idle.
module trapezoidal_linear_move_profile_unit
  import tlmp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire tlmp_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output tlmp_out_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [17:0] cfg_data
);

  tlmp_state_t state, state_next, after;

  // configuration
  logic [15:0] step_interval;
  logic [15:0] max_speed;
  logic [17:0] accel_rate;
  logic [17:0] decel_rate;
  logic [15:0] reach_range;

  // motion state
  logic signed [19:0] cur [3];
  logic signed [19:0] tgt [3];
  logic [15:0]        speed;
  logic [31:0]        last_step;
  logic               move_active;

  // working registers
  logic [19:0] mag [3];
  logic        neg [3];
  logic [1:0]  idx;
  logic [15:0] dt;
  logic [41:0] acc;
  logic [63:0] prod;
  logic [39:0] dd;
  logic [20:0] dist_root;
  logic [23:0] stepsz;
  logic        decel_mode;
  logic        flag_arrived;
  logic        flag_stepped;

  logic           accept;
  logic [31:0]    elapsed;
  logic           take_step;
  logic signed [20:0] diff [3];
  logic [31:0]    mul_a, mul_b;
  logic [63:0]    mul_p;
  tlmp_iter_req_t iter_req;
  logic [47:0]    iter_num;
  logic [20:0]    iter_den;
  logic           iter_done;
  logic [24:0]    iter_res;
  logic [24:0]    quo;
  logic signed [25:0] pos_sum;
  logic [25:0]    spd_sum;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE) || out_valid;
  assign accept    = in_valid && !in_stall;
  assign elapsed   = in_data.now_ms - last_step;
  assign take_step = (in_data.operation == OP_TICK) && move_active &&
                     (elapsed >= {16'b0, step_interval});

  // quotient by 1000 from the reciprocal product
  assign quo = prod[62:38];

  // per-axis remaining distance
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {tgt[i][19], tgt[i]} - {cur[i][19], cur[i]};
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ_MUL: begin
        mul_a = {12'b0, mag[idx]};
        mul_b = {12'b0, mag[idx]};
      end
      ST_REACH: begin
        mul_a = {16'b0, reach_range};
        mul_b = {16'b0, reach_range};
      end
      ST_DD: begin
        mul_a = {11'b0, iter_res[20:0]};
        mul_b = {14'b0, decel_rate};
      end
      ST_SS: begin
        mul_a = {16'b0, speed};
        mul_b = {16'b0, speed};
      end
      ST_RATE: begin
        mul_a = {14'b0, decel_mode ? decel_rate : accel_rate};
        mul_b = {16'b0, dt};
      end
      ST_RATE_GO: begin
        mul_a = {1'b0, prod[33:3]};
        mul_b = RECIP_125;
      end
      ST_STEP: begin
        mul_a = {16'b0, speed};
        mul_b = {16'b0, dt};
      end
      ST_STEP_GO: begin
        mul_a = {1'b0, prod[33:3]};
        mul_b = RECIP_125;
      end
      ST_MV_MUL: begin
        mul_a = {12'b0, mag[idx]};
        mul_b = {8'b0, stepsz};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // next state and requests to the shared unit
  always_comb begin
    state_next = state;
    iter_req   = '0;
    iter_num   = prod[47:0];
    iter_den   = dist_root;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = take_step ? ST_SQ_MUL : ST_DONE;
      end
      ST_SQ_MUL:  state_next = ST_SQ_ACC;
      ST_SQ_ACC:  state_next = (idx == 2'd2) ? ST_REACH : ST_SQ_MUL;
      ST_REACH:   state_next = ST_ARR_CMP;
      ST_ARR_CMP: begin
        if (acc <= {10'b0, prod[31:0]}) begin
          state_next = ST_DONE;
        end else begin
          iter_req.start = 1'b1;
          iter_req.sqrt  = 1'b1;
          iter_num       = {6'b0, acc};
          state_next     = ST_WAIT;
        end
      end
      ST_DD:        state_next = ST_SS;
      ST_SS:        state_next = ST_DEC_CMP;
      ST_DEC_CMP:   state_next = ST_RATE;
      ST_RATE:      state_next = ST_RATE_GO;
      ST_RATE_GO:   state_next = ST_SPEED;
      ST_SPEED:     state_next = ST_STEP;
      ST_STEP:      state_next = ST_STEP_GO;
      ST_STEP_GO:   state_next = ST_STEP_SAVE;
      ST_STEP_SAVE: state_next = ST_MV_MUL;
      ST_MV_MUL:    state_next = ST_MV_GO;
      ST_MV_GO: begin
        // rounded quotient: add half the divisor first
        iter_req.start = 1'b1;
        iter_num       = prod[47:0] + {28'b0, dist_root[20:1]};
        iter_den       = dist_root;
        state_next     = ST_WAIT;
      end
      ST_MV_UPD:  state_next = (idx == 2'd2) ? ST_DONE : ST_MV_MUL;
      ST_WAIT: begin
        if (iter_done) state_next = after;
      end
      ST_DONE:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // position and speed sums; the position saturates to the 20-bit range on update
  always_comb begin
    if (neg[idx]) pos_sum = {{6{cur[idx][19]}}, cur[idx]} - {1'b0, iter_res};
    else          pos_sum = {{6{cur[idx][19]}}, cur[idx]} + {1'b0, iter_res};
    spd_sum = {10'b0, speed} + {1'b0, quo};
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval <= RST_STEP_INTERVAL;
      max_speed     <= RST_MAX_SPEED;
      accel_rate    <= RST_ACCEL;
      decel_rate    <= RST_DECEL;
      reach_range   <= RST_REACH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEP_INTERVAL: step_interval <= cfg_data[15:0];
        REG_MAX_SPEED:     max_speed     <= cfg_data[15:0];
        REG_ACCEL:         accel_rate    <= cfg_data;
        REG_DECEL:         decel_rate    <= cfg_data;
        REG_REACH:         reach_range   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // motion state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        cur[i] <= '0;
        tgt[i] <= '0;
      end
      speed        <= '0;
      last_step    <= '0;
      move_active  <= 1'b0;
      flag_arrived <= 1'b0;
      flag_stepped <= 1'b0;
      idx          <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            flag_arrived <= 1'b0;
            flag_stepped <= 1'b0;
            idx          <= '0;
            acc          <= '0;
            if (take_step) begin
              last_step <= in_data.now_ms;
              dt        <= (elapsed[31:16] != 16'd0) ? 16'hFFFF : elapsed[15:0];
              for (int i = 0; i < 3; i++) begin
                neg[i] <= diff[i][20];
                mag[i] <= diff[i][20] ? 20'(-diff[i]) : diff[i][19:0];
              end
            end else if (in_data.operation == OP_TARGET) begin
              tgt[0]      <= in_data.coord_x;
              tgt[1]      <= in_data.coord_y;
              tgt[2]      <= in_data.coord_z;
              move_active <= 1'b1;
              last_step   <= in_data.now_ms;
            end else if (in_data.operation == OP_LOAD) begin
              cur[0] <= in_data.coord_x;
              cur[1] <= in_data.coord_y;
              cur[2] <= in_data.coord_z;
            end
          end
        end
        ST_SQ_MUL: prod <= mul_p;
        ST_SQ_ACC: begin
          acc <= acc + prod[41:0];
          idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
        end
        ST_REACH: prod <= mul_p;
        ST_ARR_CMP: begin
          after <= ST_DD;
          if (acc <= {10'b0, prod[31:0]}) begin
            speed        <= '0;
            move_active  <= 1'b0;
            flag_arrived <= 1'b1;
          end
        end
        ST_DD: begin
          dist_root <= iter_res[20:0];
          prod      <= mul_p;
        end
        ST_SS: begin
          dd   <= prod[39:0];
          prod <= mul_p;
        end
        ST_DEC_CMP: decel_mode <= ({1'b0, dd, 1'b0} <= {10'b0, prod[31:0]});
        ST_RATE:    prod <= mul_p;
        ST_RATE_GO: prod <= mul_p;
        ST_SPEED: begin
          if (decel_mode) begin
            speed <= (quo >= {9'b0, speed}) ? 16'd0 : speed - quo[15:0];
          end else begin
            speed <= (spd_sum > {10'b0, max_speed}) ? max_speed : spd_sum[15:0];
          end
        end
        ST_STEP:    prod <= mul_p;
        ST_STEP_GO: prod <= mul_p;
        ST_STEP_SAVE: begin
          stepsz <= prod[61:38];
          idx    <= '0;
        end
        ST_MV_MUL: begin
          prod  <= mul_p;
          after <= ST_MV_UPD;
        end
        ST_MV_UPD: begin
          if (pos_sum > 26'sd524287)       cur[idx] <= 20'sh7FFFF;
          else if (pos_sum < -26'sd524288) cur[idx] <= 20'sh80000;
          else                             cur[idx] <= pos_sum[19:0];
          idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
          if (idx == 2'd2) flag_stepped <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE) begin
      out_valid          <= 1'b1;
      out_data.pos_x     <= cur[0];
      out_data.pos_y     <= cur[1];
      out_data.pos_z     <= cur[2];
      out_data.speed_now <= speed;
      out_data.moving    <= move_active;
      out_data.arrived   <= flag_arrived;
      out_data.stepped   <= flag_stepped;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  tlmp_iter u_iter (
    .clk  (clk),
    .rst  (rst),
    .req  (iter_req),
    .num  (iter_num),
    .den  (iter_den),
    .done (iter_done),
    .res  (iter_res)
  );

endmodule
`default_nettype wire

[hw/rtl/tlmp_iter.sv]
`default_nettype none
// shared bit-serial unit: restoring divide or integer square root, one bit per cycle
module tlmp_iter
  import tlmp_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tlmp_iter_req_t req,
  input  wire logic [47:0]    num,
  input  wire logic [20:0]    den,
  output logic                done,
  output logic [24:0]         res
);

  logic        mode_sqrt;
  logic [47:0] work;
  logic [22:0] rem;
  logic [20:0] dsor;
  logic [4:0]  cnt;

  logic [24:0] rem_sh;
  logic [24:0] trial;
  logic [24:0] diff;
  logic        ge;

  // one trial subtraction per cycle
  always_comb begin
    if (mode_sqrt) begin
      rem_sh = {rem, work[47:46]};
      trial  = {2'b00, res[20:0], 2'b01};
    end else begin
      rem_sh = {1'b0, rem, work[47]};
      trial  = {4'b0000, dsor};
    end
    ge   = rem_sh >= trial;
    diff = rem_sh - trial;
  end

  // iteration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      mode_sqrt <= req.sqrt;
      dsor      <= den;
      res       <= '0;
      done      <= 1'b0;
      if (req.sqrt) begin
        work <= {num[41:0], 6'b0};
        rem  <= '0;
        cnt  <= SQRT_STEPS;
      end else begin
        // quotient is known to fit 25 bits, so the top bits start as remainder
        work <= {num[24:0], 23'b0};
        rem  <= num[47:25];
        cnt  <= DIV_STEPS;
      end
    end else if (cnt != 5'd0) begin
      rem  <= ge ? diff[22:0] : rem_sh[22:0];
      res  <= {res[23:0], ge};
      work <= mode_sqrt ? {work[45:0], 2'b00} : {work[46:0], 1'b0};
      cnt  <= cnt - 5'd1;
      done <= (cnt == 5'd1);
    end else begin
      done <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tlmp_checker.sv]
`default_nettype none
`include "trapezoidal_linear_move_profile_unit_macros.svh"
// port-level checks on the move profile unit
module tlmp_checker
  import tlmp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire tlmp_out_t out_data
);

  // a pending result is not dropped while stalled
  `TLMP_IMPLY_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // one transaction at a time: accepting closes the input
  `TLMP_IMPLY_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

  // a tick may arrive or step, never both
  `TLMP_ASSERT(a_arrive_step_excl, !(out_valid && out_data.arrived && out_data.stepped))

  // arrival stops the move
  `TLMP_IMPLY(a_arrive_stops, out_valid && out_data.arrived,
              !out_data.moving && (out_data.speed_now == 16'd0))

endmodule

bind trapezoidal_linear_move_profile_unit tlmp_checker u_tlmp_checker (.*);
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
`default_nettype wire

module testbench;
  import tlmp_pkg::*;

  // expected move results, compared in order of arrival
  class move_scoreboard;
    // configuration copy
    bit [15:0] interval_ms;
    bit [15:0] speed_cap;
    bit [17:0] accel;
    bit [17:0] decel;
    bit [15:0] reach;
    // state copy
    longint cur[3];
    longint tgt[3];
    longint spd;
    bit [31:0] last_ms;
    bit active;
    tlmp_out_t pending[$];
    int errors;

    function void init();
      interval_ms = RST_STEP_INTERVAL;
      speed_cap = RST_MAX_SPEED;
      accel = RST_ACCEL;
      decel = RST_DECEL;
      reach = RST_REACH;
      for (int i = 0; i < 3; i++) begin
        cur[i] = 0;
        tgt[i] = 0;
      end
      spd = 0;
      last_ms = 0;
      active = 0;
      errors = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [17:0] val);
      case (idx)
        REG_STEP_INTERVAL: interval_ms = val[15:0];
        REG_MAX_SPEED:     speed_cap = val[15:0];
        REG_ACCEL:         accel = val;
        REG_DECEL:         decel = val;
        REG_REACH:         reach = val[15:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // note an accepted input and queue what it should produce
    function void note_input(tlmp_in_t t);
      tlmp_out_t o;
      bit [31:0] elapsed;
      longint unsigned dt, d2, root, stp, dl, mv;
      longint unsigned mag[3];
      longint d[3];
      longint p;
      o = '0;
      if (t.operation == OP_TICK) begin
        elapsed = t.now_ms - last_ms;
        if (active && elapsed >= interval_ms) begin
          last_ms = t.now_ms;
          dt = (elapsed > 65535) ? 65535 : elapsed;
          d2 = 0;
          for (int i = 0; i < 3; i++) begin
            d[i] = tgt[i] - cur[i];
            mag[i] = (d[i] < 0) ? -d[i] : d[i];
            d2 += mag[i] * mag[i];
          end
          if (d2 <= longint'(reach) * reach) begin
            spd = 0;
            active = 0;
            o.arrived = 1;
          end else begin
            root = int_sqrt(d2);
            if (root * 2 * decel <= spd * spd) begin
              dl = decel * dt / 1000;
              spd = (dl >= spd) ? 0 : spd - dl;
            end else begin
              spd += accel * dt / 1000;
              if (spd > speed_cap) spd = speed_cap;
            end
            stp = spd * dt / 1000;
            for (int i = 0; i < 3; i++) begin
              mv = (mag[i] * stp + root / 2) / root;
              p = (d[i] < 0) ? cur[i] - longint'(mv) : cur[i] + longint'(mv);
              if (p > 524287) p = 524287;
              if (p < -524288) p = -524288;
              cur[i] = p;
            end
            o.stepped = 1;
          end
        end
      end else if (t.operation == OP_TARGET) begin
        tgt[0] = t.coord_x;
        tgt[1] = t.coord_y;
        tgt[2] = t.coord_z;
        active = 1;
        last_ms = t.now_ms;
      end else if (t.operation == OP_LOAD) begin
        cur[0] = t.coord_x;
        cur[1] = t.coord_y;
        cur[2] = t.coord_z;
      end
      o.pos_x = cur[0][19:0];
      o.pos_y = cur[1][19:0];
      o.pos_z = cur[2][19:0];
      o.speed_now = spd[15:0];
      o.moving = active;
      pending.push_back(o);
    endfunction

    function void check_result(tlmp_out_t got);
      tlmp_out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.pos_z !== want.pos_z || got.speed_now !== want.speed_now ||
          got.moving !== want.moving || got.arrived !== want.arrived ||
          got.stepped !== want.stepped) begin
        errors++;
        if (errors <= 10)
          $display("result differs: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  tlmp_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  tlmp_out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [17:0] cfg_data = '0;

  move_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  longint cycles;
  bit [31:0] clock_ms;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  trapezoidal_linear_move_profile_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 64'd3000000) begin
      $display("trapezoidal_linear_move_profile_unit: mismatch");
      $finish;
    end
  end

  // result side: sample at rising edge, randomize stall at falling edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic write_cfg(bit [2:0] idx, bit [17:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // one input transaction; random idle gaps before it
  task automatic send_item(tlmp_in_t t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    sb.note_input(t);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic tlmp_in_t make_item(bit [1:0] op, bit [31:0] ms,
                                          bit [19:0] x, bit [19:0] y, bit [19:0] z);
    tlmp_in_t t;
    t.operation = op;
    t.now_ms = ms;
    t.coord_x = x;
    t.coord_y = y;
    t.coord_z = z;
    return t;
  endfunction

  function automatic bit [19:0] near_coord();
    int v;
    v = $urandom_range(8000) - 4000;
    return v[19:0];
  endfunction

  // one well-formed move: load, target, then a run of ticks
  task automatic run_move(int ticks);
    send_item(make_item(OP_LOAD, clock_ms, near_coord(), near_coord(), near_coord()));
    send_item(make_item(OP_TARGET, clock_ms, near_coord(), near_coord(), near_coord()));
    for (int i = 0; i < ticks; i++) begin
      clock_ms += $urandom_range(20);
      send_item(make_item(OP_TICK, clock_ms, 20'd0, 20'd0, 20'd0));
    end
  endtask

  task automatic random_cfg();
    write_cfg(REG_STEP_INTERVAL, 18'($urandom_range(12)));
    write_cfg(REG_MAX_SPEED, 18'($urandom_range(65535)));
    write_cfg(REG_ACCEL, 18'($urandom_range(262143)));
    write_cfg(REG_DECEL, 18'($urandom_range(262143, 1)));
    write_cfg(REG_REACH, 18'($urandom_range(600)));
  endtask

  task automatic random_phase(int n);
    int done;
    tlmp_in_t t;
    done = 0;
    while (done < n) begin
      if ($urandom_range(9) < 8) begin
        run_move(10);
        done += 12;
      end else begin
        t = make_item(2'($urandom_range(3)), $urandom, 20'($urandom), 20'($urandom),
                      20'($urandom));
        send_item(t);
        done++;
      end
    end
  endtask

  initial begin
    sb = new();
    sb.init();
    send_idle_pct = 0;
    stall_pct = 0;
    cycles = 0;
    clock_ms = 100;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: reset config, extremes and every operation
    send_item(make_item(OP_TICK, 32'd50, 20'd0, 20'd0, 20'd0));
    send_item(make_item(OP_NOP, 32'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF));
    send_item(make_item(OP_LOAD, 32'd0, 20'h80000, 20'h7FFFF, 20'h80000));
    send_item(make_item(OP_TARGET, 32'hFFFF_FFF0, 20'h7FFFF, 20'h80000, 20'h7FFFF));
    send_item(make_item(OP_TICK, 32'hFFFF_FFF2, 20'd0, 20'd0, 20'd0));
    send_item(make_item(OP_TICK, 32'h0001_0000, 20'd0, 20'd0, 20'd0));
    send_item(make_item(OP_TICK, 32'h7FFF_0000, 20'd0, 20'd0, 20'd0));
    send_item(make_item(OP_LOAD, 32'd0, 20'd0, 20'd0, 20'd0));
    send_item(make_item(OP_TARGET, 32'd0, 20'd100, 20'd0, 20'd0));
    send_item(make_item(OP_TICK, 32'd10, 20'd0, 20'd0, 20'd0));
    send_item(make_item(OP_TICK, 32'd20, 20'd0, 20'd0, 20'd0));
    drain();
    write_cfg(REG_STEP_INTERVAL, 18'd0);
    write_cfg(REG_MAX_SPEED, 18'hFFFF);
    write_cfg(REG_ACCEL, 18'h3FFFF);
    write_cfg(REG_DECEL, 18'h3FFFF);
    write_cfg(REG_REACH, 18'd0);
    write_cfg(REG_NONE, 18'h12345);
    run_move(8);
    drain();
    write_cfg(REG_DECEL, 18'd0);
    write_cfg(REG_MAX_SPEED, 18'd0);
    write_cfg(REG_REACH, 18'hFFFF);
    run_move(4);
    drain();
    write_cfg(REG_STEP_INTERVAL, 18'hFFFF);

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 58; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 58; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      drain();
      random_cfg();
      random_phase(200);
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("trapezoidal_linear_move_profile_unit: match");
    else
      $display("trapezoidal_linear_move_profile_unit: mismatch");
    $finish;
  end
endmodule
